FILE: rtl/core/dfd_pkg.sv
package dfd_pkg;

	localparam int FRAME_LEN    = 16;
	localparam int FILL_W       = 4;
	localparam int MODULE_COUNT = 16;
	localparam int MOD_W        = 4;
	localparam int BLK_W        = 6;
	localparam int ENERGY_W     = 12;
	localparam int ENERGY_N     = 8;
	localparam int TAG_W        = 48;
	localparam int HALF_W       = 24;
	localparam int FINE_W       = 20;
	localparam int TICKS_W      = 20;
	localparam int PROD_W       = HALF_W + TICKS_W;
	localparam int LO_W         = PROD_W + 1;
	localparam int TS_W         = 64;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 20;

	localparam logic [CFG_IDX_W-1:0] REG_FIND_RESET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TICKS      = 2'd1;

	localparam logic [TICKS_W-1:0] TICKS_RESET = 20'd800000;
	localparam logic [7:0]         HEADER_MASK = 8'hF8;

	// payload that rides along with the timestamp computation
	typedef struct packed {
		logic [BLK_W-1:0]                   blk;
		logic [ENERGY_N-1:0][ENERGY_W-1:0]  energy;
	} event_t;

	// one complete frame, decoded
	typedef struct packed {
		logic                single;
		event_t              ev;
		logic [TAG_W-1:0]    tag;
		logic [FINE_W-1:0]   fine;
	} frame_t;

	// partial products handed to the output stage
	typedef struct packed {
		logic                valid;
		event_t              ev;
		logic [LO_W-1:0]     lo;
		logic [PROD_W-1:0]   hi;
	} result_t;

endpackage

FILE: rtl/core/dfd_ram.sv
module dfd_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/dfd_assembler.sv
module dfd_assembler import dfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] byte_in,
	input  logic       hold,
	output logic       frame_done,
	output frame_t     frame
);

	logic [FILL_W-1:0] fill_q;
	logic [7:0]        fb_q [FRAME_LEN-1];
	logic [7:0]        d [FRAME_LEN];
	logic              last;
	logic              acc;
	logic              drop;

	assign last       = (fill_q == FILL_W'(FRAME_LEN - 1));
	// stall only the closing word of a frame while a result is still in flight
	assign in_ready   = !(last && hold);
	assign acc        = in_valid && in_ready;
	assign drop       = (fill_q == '0) && ((byte_in & HEADER_MASK) == 8'h00);
	assign frame_done = acc && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (acc && !drop) begin
			fill_q <= last ? '0 : fill_q + FILL_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !drop && !last) begin
			fb_q[fill_q] <= byte_in;
		end
	end

	always_comb begin
		for (int i = 0; i < FRAME_LEN - 1; i++) begin
			d[i] = fb_q[i];
		end
		d[FRAME_LEN-1] = byte_in;
	end

	always_comb begin
		frame.single       = d[0][2];
		frame.ev.blk       = {d[0][1:0], d[1][7:4]};
		frame.ev.energy[0] = {d[1][3:0], d[2]};
		frame.ev.energy[1] = {d[3], d[4][7:4]};
		frame.ev.energy[2] = {d[4][3:0], d[5]};
		frame.ev.energy[3] = {d[6], d[7][7:4]};
		frame.ev.energy[4] = {d[7][3:0], d[8]};
		frame.ev.energy[5] = {d[9], d[10][7:4]};
		frame.ev.energy[6] = {d[10][3:0], d[11]};
		frame.ev.energy[7] = {d[12], d[13][7:4]};
		frame.tag          = {d[10], d[11], d[12], d[13], d[14], d[15]};
		frame.fine         = {d[13][3:0], d[14], d[15]};
	end

endmodule

FILE: rtl/core/dfd_stamp.sv
module dfd_stamp import dfd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               frame_done,
	input  frame_t             frame,
	input  logic               find_reset,
	input  logic [TICKS_W-1:0] ticks_per_tag,
	output result_t            res,
	output logic               busy
);

	logic                    seen_q;
	logic [MODULE_COUNT-1:0] tv_q;
	logic                    discard;
	logic [MOD_W-1:0]        mod;
	logic                    tag_we;
	logic                    rd_go;
	logic [TAG_W-1:0]        rdata;
	logic [TAG_W-1:0]        tag_s1;

	logic                    v_s1, v_s2, v_s3;
	logic                    hit_s1;
	event_t                  ev_s1, ev_s2, ev_s3;
	logic [FINE_W-1:0]       fine_s1;
	logic [LO_W-1:0]         lo_s2, lo_s3;
	logic [HALF_W-1:0]       hi_s2;
	logic [PROD_W-1:0]       hi_s3;

	assign discard = find_reset && !seen_q;
	assign mod     = frame.ev.blk[BLK_W-1 -: MOD_W];
	assign tag_we  = frame_done && !frame.single && !discard;
	assign rd_go   = frame_done && frame.single && !discard;

	// Frames complete at least sixteen words apart, so a write and a later read
	// of the same module never overlap in the pipeline.
	dfd_ram #(
		.WIDTH (TAG_W),
		.DEPTH (MODULE_COUNT)
	) u_tags (
		.clk   (clk),
		.we    (tag_we),
		.waddr (mod),
		.wdata (frame.tag),
		.raddr (mod),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			tv_q   <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
		end else begin
			if (frame_done && discard && !frame.single && (frame.tag == '0)) begin
				seen_q <= 1'b1;
			end
			if (tag_we) begin
				tv_q[mod] <= 1'b1;
			end
			v_s1 <= rd_go;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// entry never written since reset reads as zero
	assign tag_s1 = hit_s1 ? rdata : '0;

	always_ff @(posedge clk) begin
		ev_s1   <= frame.ev;
		fine_s1 <= frame.fine;
		hit_s1  <= tv_q[mod];

		ev_s2   <= ev_s1;
		lo_s2   <= LO_W'(tag_s1[HALF_W-1:0]) * LO_W'(ticks_per_tag) + LO_W'(fine_s1);
		hi_s2   <= tag_s1[TAG_W-1 -: HALF_W];

		ev_s3   <= ev_s2;
		lo_s3   <= lo_s2;
		hi_s3   <= PROD_W'(hi_s2) * PROD_W'(ticks_per_tag);
	end

	assign res.valid = v_s3;
	assign res.ev    = ev_s3;
	assign res.lo    = lo_s3;
	assign res.hi    = hi_s3;
	assign busy      = v_s1 || v_s2 || v_s3;

endmodule

FILE: rtl/core/detector_event_frame_decoder.sv
// Detector event frame decoder.
// Input channel (in_valid/in_ready/byte_in) takes one raw stream word per
// cycle. Words are gathered into 16-word frames; a frame opens only on a
// header word (top five bits not all zero), other words at a frame start are
// accepted and dropped. Time-tag frames update the per-module tag table and
// produce nothing; singles frames produce one output word on the out channel
// (out_valid/out_ready) with block, eight energies and the timestamp
// tag * ticks_per_tag + fine time, modulo 2^64.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always
// ready; index 0 is find_reset (bit 0), index 1 is ticks_per_tag. Write it
// only while the block is idle.
// After the edge that accepts the last word of a singles frame, the result
// passes the tag table read, the low and high partial products and the final
// add into the output register. Throughput: one input word per cycle unless
// a closing word is held, one result per 16 words at most. When the receiver
// stalls, the result holds in the output register and the next frame keeps
// filling; only its closing word waits until the pipeline and output
// register are free.
// Reset clears the fill count, the tag table valid bits (all tags read as
// zero), the zero-tag search flag, and restores find_reset=1, ticks=800000.
module detector_event_frame_decoder import dfd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            byte_in,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [BLK_W-1:0]      block_id,
	output logic [ENERGY_W-1:0]   energy_a,
	output logic [ENERGY_W-1:0]   energy_b,
	output logic [ENERGY_W-1:0]   energy_c,
	output logic [ENERGY_W-1:0]   energy_d,
	output logic [ENERGY_W-1:0]   energy_e,
	output logic [ENERGY_W-1:0]   energy_f,
	output logic [ENERGY_W-1:0]   energy_g,
	output logic [ENERGY_W-1:0]   energy_h,
	output logic [TS_W-1:0]       timestamp
);

	logic               find_reset_q;
	logic [TICKS_W-1:0] ticks_q;
	logic               out_valid_q;
	event_t             ev_q;
	logic [TS_W-1:0]    ts_q;

	logic               hold;
	logic               frame_done;
	frame_t             frame;
	result_t            res;
	logic               busy;

	// configuration registers: always ready, out-of-range indexes ignored
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			find_reset_q <= 1'b1;
			ticks_q      <= TICKS_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FIND_RESET: find_reset_q <= cfg_data[0];
				REG_TICKS:      ticks_q      <= cfg_data[TICKS_W-1:0];
				default:        ;
			endcase
		end
	end

	// hold the closing word of a frame while a result could still collide
	assign hold = busy || (out_valid_q && !out_ready);

	dfd_assembler u_asm (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.byte_in    (byte_in),
		.hold       (hold),
		.frame_done (frame_done),
		.frame      (frame)
	);

	dfd_stamp u_stamp (
		.clk           (clk),
		.arst_n        (arst_n),
		.frame_done    (frame_done),
		.frame         (frame),
		.find_reset    (find_reset_q),
		.ticks_per_tag (ticks_q),
		.res           (res),
		.busy          (busy)
	);

	// output register: load on a finished result, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			ev_q <= res.ev;
			ts_q <= TS_W'({res.hi, HALF_W'(0)}) + TS_W'(res.lo);
		end
	end

	assign out_valid = out_valid_q;
	assign block_id  = ev_q.blk;
	assign energy_a  = ev_q.energy[0];
	assign energy_b  = ev_q.energy[1];
	assign energy_c  = ev_q.energy[2];
	assign energy_d  = ev_q.energy[3];
	assign energy_e  = ev_q.energy[4];
	assign energy_f  = ev_q.energy[5];
	assign energy_g  = ev_q.energy[6];
	assign energy_h  = ev_q.energy[7];
	assign timestamp = ts_q;

endmodule

FILE: rtl/core/dfd_checker.sv
module dfd_checker import dfd_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [TS_W-1:0]       timestamp
);

	// a stalled result keeps its word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(timestamp))
		else $error("output word changed while stalled");

	// results are at least one frame apart, never back to back
	a_out_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid)
		else $error("two output words in consecutive cycles");

	// a new result follows an input word accepted ahead of the stage and output registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 4))
		else $error("output word without matching closing input word");

	// configuration port never stalls
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind detector_event_frame_decoder dfd_checker u_dfd_checker (.*);

FILE: tb/detector_event_frame_decoder_test.sv
module detector_event_frame_decoder_test;
	import dfd_pkg::*;

	// spare register slots; writes there must leave the decoder untouched
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

	localparam int ROWS   = 14;
	localparam int PHASES = 5;

	// one decoded singles word as it leaves the block
	typedef struct packed {
		logic [BLK_W-1:0]                   blk;
		logic [ENERGY_N-1:0][ENERGY_W-1:0]  en;
		logic [TS_W-1:0]                    ts;
	} hit_t;

	// directed stimulus: a lone stray word or a whole frame, first word in the
	// highest used byte of raw; typed rows carry their result written out by hand
	typedef struct packed {
		logic [4:0]          nbytes;
		logic [127:0]        raw;
		logic                typed;
		logic [BLK_W-1:0]    blk;
		logic [ENERGY_W-1:0] en;
		logic [TS_W-1:0]     ts;
	} row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [7:0]            byte_in;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  out_valid;
	logic                  out_ready;
	logic [BLK_W-1:0]      block_id;
	logic [ENERGY_W-1:0]   energy_a;
	logic [ENERGY_W-1:0]   energy_b;
	logic [ENERGY_W-1:0]   energy_c;
	logic [ENERGY_W-1:0]   energy_d;
	logic [ENERGY_W-1:0]   energy_e;
	logic [ENERGY_W-1:0]   energy_f;
	logic [ENERGY_W-1:0]   energy_g;
	logic [ENERGY_W-1:0]   energy_h;
	logic [TS_W-1:0]       timestamp;

	// decoder copy: frame assembly, tag table, zero-tag search, registers
	logic [7:0]         frame_buf [FRAME_LEN-1];
	int unsigned        fill;
	logic [TAG_W-1:0]   tag_table [MODULE_COUNT];
	bit                 zero_tag_found;
	bit                 find_reset_q;
	logic [TICKS_W-1:0] ticks_q;

	hit_t        expected_hits [$];
	int unsigned words_taken;
	int unsigned mismatches;
	int unsigned calm_in;
	int unsigned calm_out;

	string energy_name [ENERGY_N] = '{"energy_a", "energy_b", "energy_c", "energy_d",
		"energy_e", "energy_f", "energy_g", "energy_h"};

	// Directed rows, run under the reset settings (zero-tag search on,
	// 800000 ticks per tag).
	row_t script [ROWS] = '{
		// stray words at a frame start: lowest and highest non-header value
		'{5'd1,  128'h00, 1'b0, '0, '0, '0},
		'{5'd1,  128'h07, 1'b0, '0, '0, '0},
		// singles frame while the zero tag is still being searched: dropped
		'{5'd16, 128'hFC12_3456_789A_BCDE_F012_3456_789A_BCDE, 1'b0, '0, '0, '0},
		// nonzero time tag during the search: dropped, not stored
		'{5'd16, 128'h0800_0000_0000_0000_0000_0000_0000_0001, 1'b0, '0, '0, '0},
		// zero time tag ends the search and is itself dropped
		'{5'd16, 128'hF8FF_FFFF_FFFF_FFFF_FFFF_0000_0000_0000, 1'b0, '0, '0, '0},
		// all-ones singles frame: block 63, full energies, tag still zero
		'{5'd16, {16{8'hFF}}, 1'b1, 6'h3F, 12'hFFF, 64'h0000_0000_000F_FFFF},
		'{5'd1,  128'h05, 1'b0, '0, '0, '0},
		// smallest singles header, everything else zero
		'{5'd16, 128'h0C00_0000_0000_0000_0000_0000_0000_0000, 1'b1, '0, '0, '0},
		// largest tag for module 15, then a singles frame that uses it
		'{5'd16, 128'hFBF0_0000_0000_0000_0000_FFFF_FFFF_FFFF, 1'b0, '0, '0, '0},
		'{5'd16, 128'hFFF1_2345_6789_ABCD_EF01_2345_6789_ABCD, 1'b0, '0, '0, '0},
		// tag of one for module 0, then a singles frame with full fine time
		'{5'd16, 128'h0800_0000_0000_0000_0000_0000_0000_0001, 1'b0, '0, '0, '0},
		'{5'd16, 128'h0C0A_BCDE_F012_3456_789A_BCDE_FFFF_FFFF, 1'b0, '0, '0, '0},
		// a zero tag after the search is stored like any other
		'{5'd16, 128'hFBF0_0000_0000_0000_0000_0000_0000_0000, 1'b0, '0, '0, '0},
		'{5'd16, {16{8'hFF}}, 1'b1, 6'h3F, 12'hFFF, 64'h0000_0000_000F_FFFF}
	};

	detector_event_frame_decoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.byte_in   (byte_in),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.block_id  (block_id),
		.energy_a  (energy_a),
		.energy_b  (energy_b),
		.energy_c  (energy_c),
		.energy_d  (energy_d),
		.energy_e  (energy_e),
		.energy_f  (energy_f),
		.energy_g  (energy_g),
		.energy_h  (energy_h),
		.timestamp (timestamp)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Feed one stream word into the frame copy; return 1 with the decoded
	// singles word when this word closes a frame that yields a result.
	function automatic bit decode_byte(input logic [7:0] b, output hit_t h);
		logic [7:0]       d [FRAME_LEN];
		logic [BLK_W-1:0] blk;
		logic [MOD_W-1:0] modn;
		logic [TAG_W-1:0] tag;
		bit               is_single;
		int               i;
		h = '0;
		// drop a non-header word at a frame start
		if (fill == 0 && (b & HEADER_MASK) == 8'h00)
			return 1'b0;
		words_taken++;
		if (fill < FRAME_LEN - 1) begin
			frame_buf[fill] = b;
			fill++;
			return 1'b0;
		end
		for (i = 0; i < FRAME_LEN - 1; i++)
			d[i] = frame_buf[i];
		d[FRAME_LEN-1] = b;
		fill = 0;

		is_single = d[0][2];
		blk       = {d[0][1:0], d[1][7:4]};
		modn      = blk[5:2];
		tag       = {d[10], d[11], d[12], d[13], d[14], d[15]};

		// while searching for the zero tag, drop every frame
		if (find_reset_q && !zero_tag_found) begin
			if (!is_single && tag == '0)
				zero_tag_found = 1'b1;
			return 1'b0;
		end
		if (!is_single) begin
			tag_table[modn] = tag;
			return 1'b0;
		end

		h.blk   = blk;
		h.en[0] = {d[1][3:0], d[2]};
		h.en[1] = {d[3], d[4][7:4]};
		h.en[2] = {d[4][3:0], d[5]};
		h.en[3] = {d[6], d[7][7:4]};
		h.en[4] = {d[7][3:0], d[8]};
		h.en[5] = {d[9], d[10][7:4]};
		h.en[6] = {d[10][3:0], d[11]};
		h.en[7] = {d[12], d[13][7:4]};
		// coarse tag scaled by ticks, plus fine time, wrapping at 64 bits
		h.ts    = {16'h0, tag_table[modn]} * {44'h0, ticks_q}
			+ {44'h0, d[13][3:0], d[14], d[15]};
		return 1'b1;
	endfunction

	// Wait count for one word; now and then run a stretch with no waiting.
	function automatic int unsigned draw_wait(inout int unsigned calm);
		if (calm != 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0)
			calm = $urandom_range(20, 60);
		return $urandom_range(0, 9);
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		if (mismatches < 40)
			$display("%0t %s: got %0h, want %0h", $time, what, got, want);
		mismatches++;
	endtask

	// Offer one word on the input channel. Valid stays high from the previous
	// word unless a gap is drawn, so it is never lowered and raised in one step.
	task automatic push_byte(input logic [7:0] b, input bit typed, input hit_t want);
		int unsigned gap;
		hit_t        h;
		gap = draw_wait(calm_in);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		byte_in  <= b;
		do @(posedge clk); while (!in_ready);
		// accepted at this edge: advance the frame copy
		if (decode_byte(b, h))
			expected_hits.insert(expected_hits.size(), typed ? want : h);
	endtask

	// Hold a register write until the port takes it, then mirror it locally.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_FIND_RESET: find_reset_q = val[0];
			REG_TICKS:      ticks_q = val;
			default: ;
		endcase
	endtask

	// Stop the input, let every expected word come out, then let a time-tag
	// frame still in the pipe land in the tag table.
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_hits.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Mostly well-formed frames with random content; sometimes stray words at
	// a frame start, sometimes a run of junk that shifts the frame boundary.
	task automatic send_random_frame();
		logic [7:0]       fr [FRAME_LEN];
		logic [BLK_W-1:0] blk;
		logic [TAG_W-1:0] tag;
		bit               is_single;
		int unsigned      k;
		int unsigned      n;
		if ($urandom_range(0, 7) == 0) begin
			n = $urandom_range(1, 3);
			for (k = 0; k < n; k++)
				push_byte(8'($urandom_range(0, 7)), 1'b0, '0);
		end else if ($urandom_range(0, 11) == 0) begin
			n = $urandom_range(1, 15);
			for (k = 0; k < n; k++)
				push_byte(8'($urandom), 1'b0, '0);
		end

		is_single = $urandom_range(0, 9) < 7;
		blk = 6'($urandom);
		// crowd half the frames onto two modules so tags get reused
		if ($urandom_range(0, 1) == 1)
			blk[5:2] = ($urandom_range(0, 1) == 1) ? 4'hF : 4'h0;
		for (k = 0; k < FRAME_LEN; k++)
			fr[k] = 8'($urandom);
		fr[0]      = {5'($urandom_range(1, 31)), is_single, blk[5:4]};
		fr[1][7:4] = blk[3:0];
		if (!is_single) begin
			case ($urandom_range(0, 5))
				0:       tag = '0;
				1:       tag = '1;
				default: tag = {16'($urandom), $urandom};
			endcase
			{fr[10], fr[11], fr[12], fr[13], fr[14], fr[15]} = tag;
		end
		for (k = 0; k < FRAME_LEN; k++)
			push_byte(fr[k], 1'b0, '0);
	endtask

	// Output side: stall for a drawn wait before each word, then hold ready
	// until a word is taken and compare it with the oldest expectation.
	initial begin
		int unsigned stall;
		hit_t        got;
		hit_t        want;
		int          i;
		out_ready = 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			stall = draw_wait(calm_out);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			got.blk = block_id;
			got.en  = {energy_h, energy_g, energy_f, energy_e,
				energy_d, energy_c, energy_b, energy_a};
			got.ts  = timestamp;
			if (expected_hits.size() == 0) begin
				report_mismatch("word with nothing expected", 64'(got.blk), '0);
			end else begin
				want = expected_hits.pop_front();
				if (got.blk !== want.blk)
					report_mismatch("block_id", 64'(got.blk), 64'(want.blk));
				for (i = 0; i < ENERGY_N; i++)
					if (got.en[i] !== want.en[i])
						report_mismatch(energy_name[i], 64'(got.en[i]), 64'(want.en[i]));
				if (got.ts !== want.ts)
					report_mismatch("timestamp", got.ts, want.ts);
			end
		end
	end

	// Stimulus: reset, directed rows, then random phases under several settings.
	initial begin
		row_t        r;
		hit_t        want;
		int          i;
		int          k;
		int          ph;
		int unsigned base_words;

		arst_n         = 1'b0;
		in_valid       = 1'b0;
		byte_in        = 8'h00;
		cfg_valid      = 1'b0;
		cfg_index      = REG_FIND_RESET;
		cfg_data       = '0;
		fill           = 0;
		zero_tag_found = 1'b0;
		find_reset_q   = 1'b1;
		ticks_q        = TICKS_RESET;
		words_taken    = 0;
		mismatches     = 0;
		calm_in        = 0;
		calm_out       = 0;
		for (i = 0; i < MODULE_COUNT; i++)
			tag_table[i] = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// walk the directed rows; typed rows override the computed word
		for (i = 0; i < ROWS; i++) begin
			r = script[i];
			want.blk = r.blk;
			for (k = 0; k < ENERGY_N; k++)
				want.en[k] = r.en;
			want.ts = r.ts;
			for (k = 0; k < int'(r.nbytes); k++)
				push_byte(r.raw[8*(int'(r.nbytes)-1-k) +: 8], r.typed, want);
		end

		// random phases; registers change only once the block is drained
		for (ph = 0; ph < PHASES; ph++) begin
			drain();
			case (ph)
				0: begin
					// spare slots first, so the real writes below decide the mode
					write_reg(REG_SPARE_LO, '1);
					write_reg(REG_SPARE_HI, '0);
					write_reg(REG_FIND_RESET, {19'($urandom), 1'b0});
					write_reg(REG_TICKS, 20'd1);
				end
				1: begin
					write_reg(REG_FIND_RESET, {19'($urandom), 1'b1});
					write_reg(REG_TICKS, 20'hFFFFF);
				end
				2: begin
					// zero ticks: timestamp collapses to the fine time
					write_reg(REG_FIND_RESET, 20'd0);
					write_reg(REG_TICKS, 20'd0);
				end
				3: begin
					write_reg(REG_TICKS, 20'($urandom_range(1, 20'hFFFFF)));
					write_reg(REG_FIND_RESET, 20'd1);
				end
				default: begin
					write_reg(REG_FIND_RESET, 20'd0);
					write_reg(REG_TICKS, 20'($urandom_range(1, 20'hFFFFF)));
				end
			endcase
			cfg_valid <= 1'b0;
			base_words = words_taken;
			while (words_taken - base_words < 110)
				send_random_frame();
		end

		in_valid <= 1'b0;
		while (expected_hits.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (mismatches == 0)
			$display("detector_event_frame_decoder: match");
		else
			$display("detector_event_frame_decoder: mismatch");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#5000000;
		$display("detector_event_frame_decoder: mismatch");
		$finish;
	end

endmodule
